>>> rtl/mi3_pkg.sv
// ----------------------------------------------------------------------------
// mi3_pkg
// widths and the item type shared by the 3x3 inverse front, queue and back
// ----------------------------------------------------------------------------
package mi3_pkg;

  localparam int ELEM_W  = 16;               // q8.8 element
  localparam int FRAC_W  = 8;
  localparam int PROD_W  = 2 * ELEM_W;       // 2x2 minor product
  localparam int COF_W   = PROD_W + 1;       // cofactor
  localparam int DET_W   = 3 * ELEM_W + 1;   // exact determinant
  localparam int DMAG_W  = DET_W - 1;        // determinant magnitude
  localparam int MAG_W   = COF_W - 1;        // cofactor magnitude
  localparam int QSH     = FRAC_W + 16;      // q16.16 scaling shift
  localparam int REM_W   = MAG_W + QSH;      // dividend / remainder
  localparam int Q_W     = 32;               // quotient bits
  localparam int CMP_W   = DMAG_W + Q_W;     // width of shifted divisor
  localparam int NLANE   = 9;
  localparam int DSTAGES = Q_W;              // one quotient bit per stage
  localparam int IN_DW   = NLANE * ELEM_W;
  localparam int OUT_DW  = ((NLANE * Q_W + DET_W + 7) / 8) * 8;

  typedef struct packed {
    logic [NLANE-1:0][COF_W-1:0] cof;   // cofactors, row major
    logic [DET_W-1:0]            det;
  } mi3_item_t;

endpackage

>>> rtl/matrix3x3_inverse_core.sv
// throughput: one matrix per cycle when not stalled; four-stage cofactor front,
//   33-stage restoring divider (one quotient bit per stage, nine lanes) and
//   output register
// a four-entry queue lets the front keep accepting while the back is stalled
// reset: rst_n synchronous active low clears all valid bits and queue pointers
// ----------------------------------------------------------------------------
// matrix3x3_inverse_core
// adjugate inverse of a q8.8 3x3 matrix, q16.16 saturated result plus det
// ----------------------------------------------------------------------------
module matrix3x3_inverse_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // m00 m01 m02 m10 m11 m12 m20 m21 m22, 16 bits each
  input  logic [mi3_pkg::IN_DW-1:0]   in_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // inv00 inv01 inv02 inv10 inv11 inv12 inv20 inv21 inv22 (32 each), det_value (49)
  output logic [mi3_pkg::OUT_DW-1:0]  out_tdata,
  // singular
  output logic                        out_tuser
);

  logic               push, q_full, pop, q_ne;
  mi3_pkg::mi3_item_t push_item, head;

  mi3_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_data   (in_tdata),
    .push      (push),
    .push_item (push_item),
    .q_full    (q_full)
  );

  mi3_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_ne),
    .head      (head)
  );

  mi3_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_ne),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_data    (out_tdata),
    .out_sing    (out_tuser)
  );

endmodule

>>> rtl/mi3_front.sv
// ----------------------------------------------------------------------------
// mi3_front
// takes a matrix and forms its cofactors and determinant over four stages
// ----------------------------------------------------------------------------
module mi3_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [mi3_pkg::IN_DW-1:0]   in_data,
  output logic                        push,
  output mi3_pkg::mi3_item_t          push_item,
  input  logic                        q_full
);

  localparam int EW = mi3_pkg::ELEM_W;
  localparam int PW = mi3_pkg::PROD_W;
  localparam int CW = mi3_pkg::COF_W;
  localparam int DW = mi3_pkg::DET_W;
  localparam int NL = mi3_pkg::NLANE;

  logic                 adv;
  logic [3:0]           v_r;
  logic signed [EW-1:0] m_r   [NL];
  logic signed [PW-1:0] pa_r  [NL];
  logic signed [PW-1:0] pb_r  [NL];
  logic signed [EW-1:0] r2_r  [3];
  logic signed [CW-1:0] cof_r [NL];
  logic signed [EW-1:0] r3_r  [3];
  logic signed [CW-1:0] cof4_r[NL];
  logic signed [DW-1:0] dp_r  [3];
  logic signed [PW-1:0] pa_nxt[NL];
  logic signed [PW-1:0] pb_nxt[NL];

  assign adv      = !(v_r[3] && q_full);
  assign in_ready = adv;
  assign push     = v_r[3] && !q_full;

  // minor products, a*d and b*c for each cofactor
  always_comb begin
    pa_nxt[0] = m_r[4] * m_r[8]; pb_nxt[0] = m_r[5] * m_r[7];
    pa_nxt[1] = m_r[5] * m_r[6]; pb_nxt[1] = m_r[3] * m_r[8];
    pa_nxt[2] = m_r[3] * m_r[7]; pb_nxt[2] = m_r[4] * m_r[6];
    pa_nxt[3] = m_r[2] * m_r[7]; pb_nxt[3] = m_r[1] * m_r[8];
    pa_nxt[4] = m_r[0] * m_r[8]; pb_nxt[4] = m_r[2] * m_r[6];
    pa_nxt[5] = m_r[1] * m_r[6]; pb_nxt[5] = m_r[0] * m_r[7];
    pa_nxt[6] = m_r[1] * m_r[5]; pb_nxt[6] = m_r[2] * m_r[4];
    pa_nxt[7] = m_r[2] * m_r[3]; pb_nxt[7] = m_r[0] * m_r[5];
    pa_nxt[8] = m_r[0] * m_r[4]; pb_nxt[8] = m_r[1] * m_r[3];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < NL; i++) begin
        m_r[i]    <= in_data[i*EW +: EW];
        pa_r[i]   <= pa_nxt[i];
        pb_r[i]   <= pb_nxt[i];
        cof_r[i]  <= {pa_r[i][PW-1], pa_r[i]} - {pb_r[i][PW-1], pb_r[i]};
        cof4_r[i] <= cof_r[i];
      end
      for (int j = 0; j < 3; j++) begin
        r2_r[j] <= m_r[j];
        r3_r[j] <= r2_r[j];
        dp_r[j] <= r3_r[j] * cof_r[j];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NL; i++) begin
      push_item.cof[i] = cof4_r[i];
    end
    push_item.det = dp_r[0] + dp_r[1] + dp_r[2];
  end

  a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_full)
    else $error("push into full queue");
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[3] && q_full) |=> v_r[3])
    else $error("front lost an item while stalled");
  a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    !v_r[3] |-> in_ready)
    else $error("front not ready with free last stage");

endmodule

>>> rtl/mi3_queue.sv
// ----------------------------------------------------------------------------
// mi3_queue
// four-entry queue of cofactor items between front and back
// ----------------------------------------------------------------------------
module mi3_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  mi3_pkg::mi3_item_t push_item,
  output logic               full,
  input  logic               pop,
  output logic               not_empty,
  output mi3_pkg::mi3_item_t head
);

  localparam int DEPTH = 4;
  localparam int AW    = $clog2(DEPTH);

  mi3_pkg::mi3_item_t mem_r [DEPTH];
  logic [AW-1:0]      wp_r, rp_r;
  logic [AW:0]        cnt_r;

  assign full      = (cnt_r == (AW+1)'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (AW+1)'(DEPTH))
    else $error("queue count overrun");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("pop from empty queue");
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("queue count did not advance");

endmodule

>>> rtl/mi3_back.sv
// ----------------------------------------------------------------------------
// mi3_back
// scales the transposed cofactors by 1/det: one quotient bit per stage
// ----------------------------------------------------------------------------
module mi3_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_not_empty,
  input  mi3_pkg::mi3_item_t          head,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [mi3_pkg::OUT_DW-1:0]  out_data,
  output logic                        out_sing
);

  localparam int NL  = mi3_pkg::NLANE;
  localparam int NS  = mi3_pkg::DSTAGES;
  localparam int CW  = mi3_pkg::COF_W;
  localparam int DW  = mi3_pkg::DET_W;
  localparam int DMW = mi3_pkg::DMAG_W;
  localparam int MW  = mi3_pkg::MAG_W;
  localparam int RW  = mi3_pkg::REM_W;
  localparam int QW  = mi3_pkg::Q_W;
  localparam int XW  = mi3_pkg::CMP_W;
  localparam int SH  = mi3_pkg::QSH;
  localparam int OW  = mi3_pkg::OUT_DW;

  logic              en;
  logic [NS:0]       v_r;
  logic [RW-1:0]     rem_r [NS+1][NL];
  logic [QW-1:0]     q_r   [NS+1][NL];
  logic [NL-1:0]     neg_r [NS+1];
  logic [NL-1:0]     ovf_r [NS+1];
  logic [DMW-1:0]    dm_r  [NS+1];
  logic [DW-1:0]     det_r [NS+1];
  logic [NS:0]       sing_r;
  logic              out_valid_r;
  logic [OW-1:0]     out_data_r, out_data_nxt;
  logic              out_sing_r;

  logic [CW-1:0]     cof_t [NL];
  logic [MW-1:0]     mag   [NL];
  logic [DMW-1:0]    dmag;
  logic [CW-1:0]     cneg  [NL];
  logic [DW-1:0]     dneg;

  assign en  = !out_valid_r || out_ready;
  assign pop = en && q_not_empty;

  // lane l is inverse element (l/3, l%3), fed by cofactor (l%3, l/3)
  always_comb begin
    dneg = -head.det;
    dmag = head.det[DW-1] ? dneg[DMW-1:0] : head.det[DMW-1:0];
    for (int l = 0; l < NL; l++) begin
      cof_t[l] = head.cof[(l % 3) * 3 + l / 3];
      cneg[l]  = -cof_t[l];
      mag[l]   = cof_t[l][CW-1] ? cneg[l][MW-1:0] : cof_t[l][MW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v_r         <= {v_r[NS-1:0], pop};
      out_valid_r <= v_r[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dm_r[0]   <= dmag;
      det_r[0]  <= head.det;
      sing_r[0] <= (head.det == '0);
      for (int l = 0; l < NL; l++) begin
        rem_r[0][l]  <= {mag[l], SH'(0)};
        q_r[0][l]    <= '0;
        neg_r[0][l]  <= cof_t[l][CW-1] ^ head.det[DW-1];
        // quotient of 2^32 or more
        ovf_r[0][l]  <= (dmag[DMW-1:SH] == '0) &&
                        (mag[l][MW-1:QW-SH] >= dmag[SH-1:0]);
      end
      for (int s = 1; s <= NS; s++) begin
        dm_r[s]   <= dm_r[s-1];
        det_r[s]  <= det_r[s-1];
        sing_r[s] <= sing_r[s-1];
        neg_r[s]  <= neg_r[s-1];
        ovf_r[s]  <= ovf_r[s-1];
        for (int l = 0; l < NL; l++) begin
          logic [XW-1:0] dk;
          logic [XW-1:0] rr;
          dk = {{QW{1'b0}}, dm_r[s-1]} << (NS - s);
          rr = {{(XW-RW){1'b0}}, rem_r[s-1][l]};
          if (rr >= dk) begin
            rem_r[s][l] <= RW'(rr - dk);
            q_r[s][l]   <= q_r[s-1][l] | (QW'(1) << (NS - s));
          end else begin
            rem_r[s][l] <= rem_r[s-1][l];
            q_r[s][l]   <= q_r[s-1][l];
          end
        end
      end
      out_data_r <= out_data_nxt;
      out_sing_r <= sing_r[NS];
    end
  end

  // sign, saturation and the singular case
  always_comb begin
    logic [QW-1:0] q;
    logic [QW-1:0] val;
    out_data_nxt = '0;
    for (int l = 0; l < NL; l++) begin
      q = q_r[NS][l];
      if (neg_r[NS][l]) begin
        if (ovf_r[NS][l] || (q[QW-1] && (q[QW-2:0] != '0)))
          val = {1'b1, {(QW-1){1'b0}}};
        else
          val = -q;
      end else begin
        if (ovf_r[NS][l] || q[QW-1])
          val = {1'b0, {(QW-1){1'b1}}};
        else
          val = q;
      end
      if (!sing_r[NS]) begin
        out_data_nxt[l*QW +: QW] = val;
      end
    end
    if (!sing_r[NS]) begin
      out_data_nxt[NL*QW +: DW] = det_r[NS];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_sing  = out_sing_r;

  a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_sing_r) |-> out_data_r == '0)
    else $error("singular result not cleared");
  a_last_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (en && v_r[NS]) |=> out_valid_r)
    else $error("last stage item not registered");
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(v_r))
    else $error("divider moved while stalled");

endmodule

>>> bench/matrix3x3_inverse_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// matrix3x3_inverse_checker
// watches both streams of the 3x3 inverse core, predicts each result word from
// the accepted matrix and compares it field by field in order
// ----------------------------------------------------------------------------
module matrix3x3_inverse_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  input  logic                        in_tready,
  input  logic [mi3_pkg::IN_DW-1:0]   in_tdata,
  input  logic                        out_tvalid,
  input  logic                        out_tready,
  input  logic [mi3_pkg::OUT_DW-1:0]  out_tdata,
  input  logic                        out_tuser,
  output int                          fail_count,
  output int                          pending_count,
  output int                          result_count,
  output int                          singular_count
);

  typedef struct packed {
    logic        sing;
    logic [48:0] det;
    logic [8:0][31:0] inv;
  } inv_result_t;

  inv_result_t inverse_q[$];

  function automatic logic [31:0] q16_quotient(longint cof, longint det);
    logic neg;
    longint unsigned num;
    longint unsigned q;
    neg = (cof < 0) != (det < 0);
    num = (cof < 0 ? -cof : cof);
    num = num << (mi3_pkg::FRAC_W + 16);
    q = num / longint'(det < 0 ? -det : det);
    if (neg) begin
      if (q > 64'h8000_0000) q = 64'h8000_0000;
      return 32'(-q);
    end
    if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
    return q[31:0];
  endfunction

  function automatic inv_result_t predict_inverse(logic [mi3_pkg::IN_DW-1:0] d);
    longint e[3][3];
    longint c[3][3];
    longint det;
    inv_result_t r;
    for (int k = 0; k < 9; k++)
      e[k/3][k%3] = longint'($signed(d[k*mi3_pkg::ELEM_W +: mi3_pkg::ELEM_W]));
    c[0][0] = e[1][1]*e[2][2] - e[1][2]*e[2][1];
    c[0][1] = e[1][2]*e[2][0] - e[1][0]*e[2][2];
    c[0][2] = e[1][0]*e[2][1] - e[1][1]*e[2][0];
    c[1][0] = e[0][2]*e[2][1] - e[0][1]*e[2][2];
    c[1][1] = e[0][0]*e[2][2] - e[0][2]*e[2][0];
    c[1][2] = e[0][1]*e[2][0] - e[0][0]*e[2][1];
    c[2][0] = e[0][1]*e[1][2] - e[0][2]*e[1][1];
    c[2][1] = e[0][2]*e[1][0] - e[0][0]*e[1][2];
    c[2][2] = e[0][0]*e[1][1] - e[0][1]*e[1][0];
    det = e[0][0]*c[0][0] + e[0][1]*c[0][1] + e[0][2]*c[0][2];
    r = '0;
    if (det == 0) begin
      r.sing = 1'b1;
      return r;
    end
    for (int k = 0; k < 9; k++) r.inv[k] = q16_quotient(c[k%3][k/3], det);
    r.det = det[48:0];
    return r;
  endfunction

  assign pending_count = inverse_q.size();

  always @(posedge clk) begin
    inv_result_t exp_r;
    logic [31:0] got;
    int errs;
    if (!rst_n) begin
      fail_count <= 0;
      result_count <= 0;
      singular_count <= 0;
      inverse_q.delete();
    end else begin
      errs = 0;
      if (in_tvalid && in_tready) inverse_q.push_back(predict_inverse(in_tdata));
      if (out_tvalid && out_tready) begin
        result_count <= result_count + 1;
        if (inverse_q.size() == 0) begin
          $error("result word with no matrix waiting");
          errs++;
        end else begin
          exp_r = inverse_q.pop_front();
          if (exp_r.sing) singular_count <= singular_count + 1;
          for (int k = 0; k < 9; k++) begin
            got = out_tdata[k*32 +: 32];
            if (got !== exp_r.inv[k]) begin
              $error("inv%0d%0d expected %h actual %h", k/3, k%3, exp_r.inv[k], got);
              errs++;
            end
          end
          if (out_tdata[288 +: 49] !== exp_r.det) begin
            $error("det_value expected %h actual %h", exp_r.det, out_tdata[288 +: 49]);
            errs++;
          end
          if (out_tuser !== exp_r.sing) begin
            $error("singular expected %b actual %b", exp_r.sing, out_tuser);
            errs++;
          end
        end
      end
      if (errs != 0) fail_count <= fail_count + errs;
    end
  end
endmodule

>>> bench/tb_matrix3x3_inverse_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_matrix3x3_inverse_core
// directed and random matrices into the inverse core with random gaps and
// back pressure; checking is done by the checker beside the block
// ----------------------------------------------------------------------------
module tb_matrix3x3_inverse_core;

  localparam int N_RANDOM = 1950;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [mi3_pkg::IN_DW-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [mi3_pkg::OUT_DW-1:0] out_tdata;
  logic out_tuser;
  int fail_count, pending_count, result_count, singular_count;
  int cycle_count = 0;
  int sent_count = 0;
  int hold_count = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  matrix3x3_inverse_core dut (.*);

  matrix3x3_inverse_checker checker_i (.*);

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [15:0] rand_elem();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'(int'($urandom_range(0, 1024)) - 512);
      3: return 16'h0100;
      4: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // receiver back pressure, mostly short gaps and now and then a long stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_count <= 0;
    end else if (hold_count > 0) begin
      out_tready <= 1'b0;
      hold_count <= hold_count - 1;
    end else if ($urandom_range(0, 199) == 0) begin
      out_tready <= 1'b0;
      hold_count <= $urandom_range(20, 80);
    end else begin
      out_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb_matrix3x3_inverse_core failed");
      $finish;
    end
  end

  task automatic send_matrix(logic [mi3_pkg::IN_DW-1:0] d, int gap);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent_count++;
  endtask

  function automatic logic [mi3_pkg::IN_DW-1:0] pack9(logic [8:0][15:0] m);
    return m;
  endfunction

  initial begin
    logic [8:0][15:0] m;
    int kind;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed, among them identity, scaled identity, singular, extremes
    send_matrix(pack9({16'h0100, 16'h0, 16'h0, 16'h0, 16'h0100, 16'h0, 16'h0, 16'h0,
                       16'h0100}), 0);
    send_matrix(pack9({16'h0001, 16'h0, 16'h0, 16'h0, 16'h0001, 16'h0, 16'h0, 16'h0,
                       16'h0001}), 0);
    send_matrix('0, 0);
    send_matrix({9{16'h8000}}, 0);
    send_matrix({9{16'h7FFF}}, 1);
    send_matrix({9{16'hFFFF}}, 0);
    send_matrix(pack9({16'h8000, 16'h0, 16'h0, 16'h0, 16'h8000, 16'h0, 16'h0, 16'h0,
                       16'h8000}), 0);
    send_matrix(pack9({16'h7FFF, 16'h0, 16'h0, 16'h0, 16'h7FFF, 16'h0, 16'h0, 16'h0,
                       16'h7FFF}), 0);
    send_matrix(pack9({16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000,
                       16'h0001, 16'h0002, 16'h0003}), 2);
    send_matrix(pack9({16'hFF00, 16'h0, 16'h0, 16'h0, 16'h0100, 16'h0, 16'h0, 16'h0,
                       16'h0100}), 0);
    send_matrix(pack9({16'h0001, 16'h0002, 16'h0003, 16'h0004, 16'h0005, 16'h0006,
                       16'h0007, 16'h0008, 16'h000A}), 0);
    send_matrix(pack9({16'h0100, 16'h0200, 16'h0300, 16'h0200, 16'h0400, 16'h0600,
                       16'h0001, 16'h0005, 16'h0009}), 0);
    send_matrix(pack9({16'h0, 16'h0, 16'h0100, 16'h0, 16'h0100, 16'h0, 16'h0100, 16'h0,
                       16'h0}), 0);
    send_matrix(pack9({16'h5555, 16'hAAAA, 16'h1234, 16'hEDCB, 16'h0F0F, 16'hF0F0,
                       16'h3333, 16'hCCCC, 16'h0101}), 0);
    for (int i = 0; i < N_RANDOM; i++) begin
      kind = $urandom_range(0, 9);
      for (int k = 0; k < 9; k++) m[k] = (kind < 6) ? 16'($urandom) : rand_elem();
      // force some singular matrices: copy or zero a row
      if (kind == 9) m[8:6] = m[2:0];
      else if (kind == 8) m[5:3] = '0;
      send_matrix(m, gap_len());
    end
    in_tvalid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("sent %0d matrices, %0d results checked, %0d singular", sent_count,
             result_count, singular_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("tb_matrix3x3_inverse_core passed");
    end else begin
      $display("tb_matrix3x3_inverse_core failed");
    end
    $finish;
  end
endmodule
